// ===== design/ttf_pkg.sv =====
// Shared types and constants for the triangle tangent frame unit.
// No dependencies; compiled first.
package ttf_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int TAN_W         = 18;
    localparam int BIT_W         = 32;
    localparam int MUL_W         = 33;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_NORM,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_INIT,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_DIV_STORE,
        S_BT_MUL,
        S_BT_ACC,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        MUL_NONE,
        MUL_DET_A, MUL_DET_B,
        MUL_RX_A,  MUL_RX_B,
        MUL_RY_A,  MUL_RY_B,
        MUL_RZ_A,  MUL_RZ_B,
        MUL_SQ0,   MUL_SQ1,   MUL_SQ2,
        MUL_BX_A,  MUL_BX_B,
        MUL_BY_A,  MUL_BY_B,
        MUL_BZ_A,  MUL_BZ_B
    } t_mul_op;

    typedef enum logic [2:0] {
        ACC_IDLE,
        ACC_LOAD,
        ACC_SUB,
        ACC_SQ_LOAD,
        ACC_SQ_ADD
    } t_acc_op;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_DET,
        DST_R0, DST_R1, DST_R2,
        DST_B0, DST_B1, DST_B2
    } t_dest;

    typedef struct packed {
        logic    store_v0;
        logic    store_v1;
        logic    store_v2;
        t_mul_op mul_op;
        t_acc_op acc_op;
        t_dest   dest;
        logic    norm_step;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    div_init;
        logic    div_step;
        logic    div_store;
        logic [1:0] comp;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic norm_done;
    } t_sts;

endpackage

// ===== design/ttf_if.sv =====
// Vertex and result channel interfaces (valid/ready beats).
// Depends on ttf_pkg.
interface ttf_vtx_if;
    import ttf_pkg::*;
    logic valid;
    logic ready;
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic signed [IN_W-1:0] tex_u;
    logic signed [IN_W-1:0] tex_v;
    logic signed [IN_W-1:0] norm_x;
    logic signed [IN_W-1:0] norm_y;
    logic signed [IN_W-1:0] norm_z;
    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                    norm_x, norm_y, norm_z, output ready);
endinterface

interface ttf_res_if;
    import ttf_pkg::*;
    logic valid;
    logic ready;
    logic signed [TAN_W-1:0] tangent_x;
    logic signed [TAN_W-1:0] tangent_y;
    logic signed [TAN_W-1:0] tangent_z;
    logic signed [BIT_W-1:0] bitangent_x;
    logic signed [BIT_W-1:0] bitangent_y;
    logic signed [BIT_W-1:0] bitangent_z;
    logic degenerate;
    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, output ready);
endinterface

// ===== design/triangle_tangent_frame_unit.sv =====
// Top level of the triangle tangent frame unit: ttf_ctrl plus ttf_dp.
// Depends on ttf_pkg, ttf_if, ttf_ctrl, ttf_dp.
//
//   channel  dir  beat                         per triangle
//   i_vtx    in   one corner (pos, uv, normal)  3 beats
//   o_res    out  tangent, bitangent, flag      1 beat
//
// Corners one and two are taken while i_vtx.ready stays high. The third corner holds
// i_vtx.ready low through the compute pass, plus any wait for the output register
// (8 products and 6 bitangent products on the one shared multiplier, up to 11
// normalize shifts, 32 root steps, three (32+FRAC_BITS)-step divisions).
// A degenerate triangle skips from the products straight to the result.
// Reset clears the corner count, the sequencer and o_res.valid.
// A result held by a stalled sink is kept in the output register; the next
// triangle's corners are still taken and its result waits for that register.
module triangle_tangent_frame_unit #(
    parameter int FRAC_BITS = ttf_pkg::FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    ttf_vtx_if.sink    i_vtx,
    ttf_res_if.source  o_res
);
    import ttf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ttf_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .o_in_ready  (i_vtx.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ttf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pos_x       (i_vtx.pos_x),
        .i_pos_y       (i_vtx.pos_y),
        .i_pos_z       (i_vtx.pos_z),
        .i_tex_u       (i_vtx.tex_u),
        .i_tex_v       (i_vtx.tex_v),
        .i_norm_x      (i_vtx.norm_x),
        .i_norm_y      (i_vtx.norm_y),
        .i_norm_z      (i_vtx.norm_z),
        .o_tangent_x   (o_res.tangent_x),
        .o_tangent_y   (o_res.tangent_y),
        .o_tangent_z   (o_res.tangent_z),
        .o_bitangent_x (o_res.bitangent_x),
        .o_bitangent_y (o_res.bitangent_y),
        .o_bitangent_z (o_res.bitangent_z),
        .o_degenerate  (o_res.degenerate)
    );

endmodule

// ===== design/ttf_ctrl.sv =====
// Sequencer for the tangent frame unit: corner count, step counters, handshakes.
// Depends on ttf_pkg; drives ttf_dp through t_cmd.
module ttf_ctrl #(
    parameter int FRAC_BITS = ttf_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ttf_pkg::t_sts i_sts,
    output ttf_pkg::t_cmd o_cmd
);
    import ttf_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW);

    t_state        r_state, n_state;
    logic [1:0]    r_corner, n_corner;
    logic [2:0]    r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          in_beat;
    logic          out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corner    <= 2'd0;
            r_op        <= 3'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corner    <= n_corner;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and counters
    always_comb begin
        n_state     = r_state;
        n_corner    = r_corner;
        n_op        = r_op;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (r_corner == 2'd1) begin
                        n_corner = 2'd2;
                    end else if (r_corner == 2'd2) begin
                        n_corner = 2'd0;
                        n_op     = 3'd0;
                        n_state  = S_MUL;
                    end else begin
                        n_corner = 2'd1;
                    end
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_op == 3'd7) begin
                    n_state = S_CHECK;
                end else begin
                    n_op    = r_op + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_CHECK: n_state = i_sts.degen ? S_OUT : S_NORM;
            S_NORM: begin
                if (i_sts.norm_done) begin
                    n_op    = 3'd0;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_op == 3'd2) begin
                    n_state = S_SQRT_INIT;
                end else begin
                    n_op    = r_op + 3'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_INIT: begin
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    n_op    = 3'd0;
                    n_state = S_DIV_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV_INIT: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CW'(NW - 1)) begin
                    n_state = S_DIV_STORE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV_STORE: begin
                if (r_op == 3'd2) begin
                    n_op    = 3'd0;
                    n_state = S_BT_MUL;
                end else begin
                    n_op    = r_op + 3'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_BT_MUL: n_state = S_BT_ACC;
            S_BT_ACC: begin
                if (r_op == 3'd5) begin
                    n_state = S_OUT;
                end else begin
                    n_op    = r_op + 3'd1;
                    n_state = S_BT_MUL;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        o_cmd.acc_op = ACC_IDLE;
        o_cmd.dest   = DST_NONE;
        o_cmd.comp   = r_op[1:0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.store_v0 = in_beat && (r_corner != 2'd1) && (r_corner != 2'd2);
                o_cmd.store_v1 = in_beat && (r_corner == 2'd1);
                o_cmd.store_v2 = in_beat && (r_corner == 2'd2);
            end
            S_MUL: begin
                unique case (r_op)
                    3'd0:    o_cmd.mul_op = MUL_DET_A;
                    3'd1:    o_cmd.mul_op = MUL_DET_B;
                    3'd2:    o_cmd.mul_op = MUL_RX_A;
                    3'd3:    o_cmd.mul_op = MUL_RX_B;
                    3'd4:    o_cmd.mul_op = MUL_RY_A;
                    3'd5:    o_cmd.mul_op = MUL_RY_B;
                    3'd6:    o_cmd.mul_op = MUL_RZ_A;
                    default: o_cmd.mul_op = MUL_RZ_B;
                endcase
            end
            S_ACC: begin
                o_cmd.acc_op = r_op[0] ? ACC_SUB : ACC_LOAD;
                if (r_op[0]) begin
                    unique case (r_op[2:1])
                        2'd0:    o_cmd.dest = DST_DET;
                        2'd1:    o_cmd.dest = DST_R0;
                        2'd2:    o_cmd.dest = DST_R1;
                        default: o_cmd.dest = DST_R2;
                    endcase
                end
            end
            S_NORM: o_cmd.norm_step = !i_sts.norm_done;
            S_SQ_MUL: begin
                unique case (r_op[1:0])
                    2'd0:    o_cmd.mul_op = MUL_SQ0;
                    2'd1:    o_cmd.mul_op = MUL_SQ1;
                    default: o_cmd.mul_op = MUL_SQ2;
                endcase
            end
            S_SQ_ACC:    o_cmd.acc_op = (r_op == 3'd0) ? ACC_SQ_LOAD : ACC_SQ_ADD;
            S_SQRT_INIT: o_cmd.sqrt_init = 1'b1;
            S_SQRT:      o_cmd.sqrt_step = 1'b1;
            S_DIV_INIT:  o_cmd.div_init = 1'b1;
            S_DIV:       o_cmd.div_step = 1'b1;
            S_DIV_STORE: o_cmd.div_store = 1'b1;
            S_BT_MUL: begin
                unique case (r_op)
                    3'd0:    o_cmd.mul_op = MUL_BX_A;
                    3'd1:    o_cmd.mul_op = MUL_BX_B;
                    3'd2:    o_cmd.mul_op = MUL_BY_A;
                    3'd3:    o_cmd.mul_op = MUL_BY_B;
                    3'd4:    o_cmd.mul_op = MUL_BZ_A;
                    default: o_cmd.mul_op = MUL_BZ_B;
                endcase
            end
            S_BT_ACC: begin
                o_cmd.acc_op = r_op[0] ? ACC_SUB : ACC_LOAD;
                if (r_op[0]) begin
                    unique case (r_op[2:1])
                        2'd0:    o_cmd.dest = DST_B0;
                        2'd1:    o_cmd.dest = DST_B1;
                        default: o_cmd.dest = DST_B2;
                    endcase
                end
            end
            S_OUT:   o_cmd.load_out = out_free;
            default: o_cmd.load_out = 1'b0;
        endcase
    end

endmodule

// ===== design/ttf_dp.sv =====
// Datapath: corner registers, shared 33x33 multiplier and accumulator,
// normalizer, bit-pair square root, restoring divider, result register.
// Depends on ttf_pkg; steered by ttf_ctrl through t_cmd.
module ttf_dp #(
    parameter int FRAC_BITS = ttf_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  ttf_pkg::t_cmd                 i_cmd,
    output ttf_pkg::t_sts                 o_sts,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_pos_x,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_pos_y,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_pos_z,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_tex_u,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_tex_v,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_norm_x,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_norm_y,
    input  logic signed [ttf_pkg::IN_W-1:0]  i_norm_z,
    output logic signed [ttf_pkg::TAN_W-1:0] o_tangent_x,
    output logic signed [ttf_pkg::TAN_W-1:0] o_tangent_y,
    output logic signed [ttf_pkg::TAN_W-1:0] o_tangent_z,
    output logic signed [ttf_pkg::BIT_W-1:0] o_bitangent_x,
    output logic signed [ttf_pkg::BIT_W-1:0] o_bitangent_y,
    output logic signed [ttf_pkg::BIT_W-1:0] o_bitangent_z,
    output logic                          o_degenerate
);
    import ttf_pkg::*;

    localparam int NW = 32 + FRAC_BITS;     // dividend bits
    localparam int TW = FRAC_BITS + 2;      // signed tangent
    localparam int PW = 2 * MUL_W;
    localparam int AW = PW + 1;
    localparam int CB = 31;                 // normalized magnitude bits

    logic signed [IN_W-1:0] r_p0 [3];
    logic signed [IN_W-1:0] r_p1 [3];
    logic signed [IN_W-1:0] r_p2 [3];
    logic signed [IN_W-1:0] r_n0 [3];
    logic signed [IN_W-1:0] r_uv0 [2];
    logic signed [IN_W-1:0] r_uv1 [2];
    logic signed [IN_W-1:0] r_uv2 [2];

    logic signed [PW-1:0]   r_prod;
    logic signed [AW-1:0]   r_acc;
    logic                   r_det_zero;
    logic                   r_det_neg;
    logic [AW-1:0]          r_rmag [3];
    logic                   r_rneg [3];
    logic [63:0]            r_sum;
    logic [63:0]            r_sv;
    logic [63:0]            r_res;
    logic [63:0]            r_bit;
    logic [NW-1:0]          r_num;
    logic [31:0]            r_rem;
    logic [TW-1:0]          r_q;
    logic signed [TW-1:0]   r_t [3];
    logic signed [BIT_W-1:0] r_bt [3];

    logic signed [TAN_W-1:0] r_o_tan [3];
    logic signed [BIT_W-1:0] r_o_bt [3];
    logic                    r_o_degen;

    logic signed [MUL_W-1:0] d1u, d1v, d2u, d2v;
    logic signed [MUL_W-1:0] e1 [3];
    logic signed [MUL_W-1:0] e2 [3];
    logic signed [MUL_W-1:0] nn [3];
    logic signed [MUL_W-1:0] tt [3];
    logic signed [MUL_W-1:0] cc [3];
    logic signed [MUL_W-1:0] op_a, op_b;

    logic signed [AW-1:0] p_ext;
    logic signed [AW-1:0] n_diff;
    logic [AW-1:0]        diff_mag;
    logic [AW-1:0]        bt_rnd;
    logic signed [BIT_W-1:0] bt_sat;

    logic [AW-1:0] r_any;
    logic [63:0]   sq_try;
    logic [31:0]   len;
    logic [CB-1:0] c_sel;
    logic [32:0]   rem2;
    logic          q_bit;
    logic          t_neg;

    // operand select
    always_comb begin
        d1u = MUL_W'(r_uv1[0]) - MUL_W'(r_uv0[0]);
        d1v = MUL_W'(r_uv1[1]) - MUL_W'(r_uv0[1]);
        d2u = MUL_W'(r_uv2[0]) - MUL_W'(r_uv0[0]);
        d2v = MUL_W'(r_uv2[1]) - MUL_W'(r_uv0[1]);
        for (int i = 0; i < 3; i++) begin
            e1[i] = MUL_W'(r_p1[i]) - MUL_W'(r_p0[i]);
            e2[i] = MUL_W'(r_p2[i]) - MUL_W'(r_p0[i]);
            nn[i] = MUL_W'(r_n0[i]);
            tt[i] = MUL_W'(r_t[i]);
            cc[i] = $signed({2'b00, r_rmag[i][CB-1:0]});
        end
        op_a = '0;
        op_b = '0;
        case (i_cmd.mul_op)
            MUL_DET_A: begin op_a = d1u;   op_b = d2v;   end
            MUL_DET_B: begin op_a = d2u;   op_b = d1v;   end
            MUL_RX_A:  begin op_a = d2v;   op_b = e1[0]; end
            MUL_RX_B:  begin op_a = d1v;   op_b = e2[0]; end
            MUL_RY_A:  begin op_a = d2v;   op_b = e1[1]; end
            MUL_RY_B:  begin op_a = d1v;   op_b = e2[1]; end
            MUL_RZ_A:  begin op_a = d2v;   op_b = e1[2]; end
            MUL_RZ_B:  begin op_a = d1v;   op_b = e2[2]; end
            MUL_SQ0:   begin op_a = cc[0]; op_b = cc[0]; end
            MUL_SQ1:   begin op_a = cc[1]; op_b = cc[1]; end
            MUL_SQ2:   begin op_a = cc[2]; op_b = cc[2]; end
            MUL_BX_A:  begin op_a = nn[1]; op_b = tt[2]; end
            MUL_BX_B:  begin op_a = nn[2]; op_b = tt[1]; end
            MUL_BY_A:  begin op_a = nn[2]; op_b = tt[0]; end
            MUL_BY_B:  begin op_a = nn[0]; op_b = tt[2]; end
            MUL_BZ_A:  begin op_a = nn[0]; op_b = tt[1]; end
            MUL_BZ_B:  begin op_a = nn[1]; op_b = tt[0]; end
            default:   begin op_a = '0;    op_b = '0;    end
        endcase
    end

    // accumulate, round and saturate
    always_comb begin
        p_ext    = AW'(r_prod);
        n_diff   = r_acc - p_ext;
        diff_mag = n_diff[AW-1] ? AW'(-n_diff) : AW'(n_diff);
        bt_rnd   = (diff_mag + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (n_diff[AW-1]) begin
            bt_sat = (bt_rnd > AW'(33'h0_8000_0000)) ? $signed(32'h8000_0000)
                                                     : $signed(-bt_rnd[31:0]);
        end else begin
            bt_sat = (bt_rnd > AW'(32'h7FFF_FFFF)) ? $signed(32'h7FFF_FFFF)
                                                   : $signed(bt_rnd[31:0]);
        end
    end

    // normalizer, root and divider support
    always_comb begin
        r_any  = r_rmag[0] | r_rmag[1] | r_rmag[2];
        sq_try = r_res + r_bit;
        len    = r_res[31:0];
        c_sel  = r_rmag[i_cmd.comp][CB-1:0];
        rem2   = {r_rem, r_num[NW-1]};
        q_bit  = (rem2 >= {1'b0, len});
        t_neg  = r_rneg[i_cmd.comp] ^ r_det_neg;
    end

    assign o_sts.degen     = r_det_zero || (r_any == '0);
    assign o_sts.norm_done = (r_any[AW-1:CB] == '0) && r_any[CB-1];

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;

        if (i_cmd.store_v0) begin
            r_p0[0]  <= i_pos_x;  r_p0[1]  <= i_pos_y;  r_p0[2] <= i_pos_z;
            r_n0[0]  <= i_norm_x; r_n0[1]  <= i_norm_y; r_n0[2] <= i_norm_z;
            r_uv0[0] <= i_tex_u;  r_uv0[1] <= i_tex_v;
        end
        if (i_cmd.store_v1) begin
            r_p1[0]  <= i_pos_x;  r_p1[1]  <= i_pos_y;  r_p1[2] <= i_pos_z;
            r_uv1[0] <= i_tex_u;  r_uv1[1] <= i_tex_v;
        end
        if (i_cmd.store_v2) begin
            r_p2[0]  <= i_pos_x;  r_p2[1]  <= i_pos_y;  r_p2[2] <= i_pos_z;
            r_uv2[0] <= i_tex_u;  r_uv2[1] <= i_tex_v;
        end

        case (i_cmd.acc_op)
            ACC_LOAD:    r_acc <= p_ext;
            ACC_SUB:     r_acc <= n_diff;
            ACC_SQ_LOAD: r_sum <= r_prod[63:0];
            ACC_SQ_ADD:  r_sum <= r_sum + r_prod[63:0];
            default:     r_sum <= r_sum;
        endcase

        case (i_cmd.dest)
            DST_DET: begin
                r_det_zero <= (n_diff == '0);
                r_det_neg  <= n_diff[AW-1];
            end
            DST_R0: begin r_rmag[0] <= diff_mag; r_rneg[0] <= n_diff[AW-1]; end
            DST_R1: begin r_rmag[1] <= diff_mag; r_rneg[1] <= n_diff[AW-1]; end
            DST_R2: begin r_rmag[2] <= diff_mag; r_rneg[2] <= n_diff[AW-1]; end
            DST_B0: r_bt[0] <= bt_sat;
            DST_B1: r_bt[1] <= bt_sat;
            DST_B2: r_bt[2] <= bt_sat;
            default: r_det_neg <= r_det_neg;
        endcase

        // coarse then fine steps until the top set bit lands on bit CB-1
        if (i_cmd.norm_step) begin
            for (int i = 0; i < 3; i++) begin
                if (r_any[AW-1:CB+8] != '0) begin
                    r_rmag[i] <= r_rmag[i] >> 8;
                end else if (r_any[AW-1:CB] != '0) begin
                    r_rmag[i] <= r_rmag[i] >> 1;
                end else if (r_any[CB-1:CB-8] == '0) begin
                    r_rmag[i] <= r_rmag[i] << 8;
                end else begin
                    r_rmag[i] <= r_rmag[i] << 1;
                end
            end
        end

        if (i_cmd.sqrt_init) begin
            r_sv  <= r_sum;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (r_sv >= sq_try) begin
                r_sv  <= r_sv - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end

        if (i_cmd.div_init) begin
            r_num <= (NW'(c_sel) << FRAC_BITS) + NW'(len >> 1);
            r_rem <= '0;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? 32'(rem2 - {1'b0, len}) : rem2[31:0];
            r_num <= r_num << 1;
            r_q   <= {r_q[TW-2:0], q_bit};
        end

        if (i_cmd.div_store) begin
            r_t[i_cmd.comp] <= t_neg ? $signed(-r_q) : $signed(r_q);
        end

        if (i_cmd.load_out) begin
            for (int i = 0; i < 3; i++) begin
                r_o_tan[i] <= o_sts.degen ? '0 : TAN_W'(r_t[i]);
                r_o_bt[i]  <= o_sts.degen ? '0 : r_bt[i];
            end
            r_o_degen <= o_sts.degen;
        end
    end

    assign o_tangent_x   = r_o_tan[0];
    assign o_tangent_y   = r_o_tan[1];
    assign o_tangent_z   = r_o_tan[2];
    assign o_bitangent_x = r_o_bt[0];
    assign o_bitangent_y = r_o_bt[1];
    assign o_bitangent_z = r_o_bt[2];
    assign o_degenerate  = r_o_degen;

endmodule

// ===== design/ttf_checker.sv =====
// Port-level checks for triangle_tangent_frame_unit, bound to the top level.
// Depends on ttf_pkg.
module ttf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic signed [ttf_pkg::TAN_W-1:0] i_tan_x,
    input logic signed [ttf_pkg::TAN_W-1:0] i_tan_y,
    input logic signed [ttf_pkg::TAN_W-1:0] i_tan_z,
    input logic signed [ttf_pkg::BIT_W-1:0] i_bt_x,
    input logic signed [ttf_pkg::BIT_W-1:0] i_bt_y,
    input logic signed [ttf_pkg::BIT_W-1:0] i_bt_z,
    input logic                           i_degen
);
    import ttf_pkg::*;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bt_x) && $stable(i_tan_x))
        else $error("stalled result beat dropped or changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degen |-> i_tan_x == '0 && i_tan_y == '0 && i_tan_z == '0
                                   && i_bt_x == '0 && i_bt_y == '0 && i_bt_z == '0)
        else $error("degenerate result with nonzero vectors");

    a_busy_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a compute pass");

endmodule

bind triangle_tangent_frame_unit ttf_checker u_ttf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_tan_x     (o_res.tangent_x),
    .i_tan_y     (o_res.tangent_y),
    .i_tan_z     (o_res.tangent_z),
    .i_bt_x      (o_res.bitangent_x),
    .i_bt_y      (o_res.bitangent_y),
    .i_bt_z      (o_res.bitangent_z),
    .i_degen     (o_res.degenerate)
);

// ===== test/triangle_tangent_frame_unit_tb.sv =====
// Testbench for triangle_tangent_frame_unit: directed corner table, then random triangles.
// Checks every result beat against a built-in tangent/bitangent predictor, or against the table for flagged rows.
// Depends on ttf_pkg, ttf_if and the design sources.
`timescale 1ns / 1ps

module triangle_tangent_frame_unit_tb;
    import ttf_pkg::*;

    localparam int ONE       = 65536;
    localparam int MAXI      = 32'h7fffffff;
    localparam int MINI      = 32'h80000000;
    localparam int N_TRI     = 634;
    localparam int WD_LIMIT  = 4000;

    typedef struct {
        logic signed [31:0] p[3];
        logic signed [31:0] uv[2];
        logic signed [31:0] n[3];
    } corner_t;

    typedef struct {
        logic signed [TAN_W-1:0] t[3];
        logic signed [BIT_W-1:0] b[3];
        logic                    dg;
    } frame_t;

    typedef struct {
        int px, py, pz, u, v, nx, ny, nz;
        bit chk;
        int tx, ty, tz, bx, by, bz;
        bit dg;
    } row_t;

    localparam int N_ROWS = 18;
    row_t dir_tab[N_ROWS] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0,              0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0,              0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0,              1, 0, 0, 0, 0, 0, 0, 1},
        '{0, 0, 0, 0, 0, 0, 0, ONE,            0, 0, 0, 0, 0, 0, 0, 0},
        '{ONE, 0, 0, ONE, 0, 0, 0, 0,          0, 0, 0, 0, 0, 0, 0, 0},
        '{0, ONE, 0, 0, ONE, 0, 0, 0,          1, ONE, 0, 0, 0, ONE, 0, 0},
        '{0, 0, 0, 0, 0, ONE, ONE, ONE,        0, 0, 0, 0, 0, 0, 0, 0},
        '{ONE, 0, 0, ONE, 0, 0, 0, 0,          0, 0, 0, 0, 0, 0, 0, 0},
        '{0, ONE, 0, ONE, 0, 0, 0, 0,          1, 0, 0, 0, 0, 0, 0, 1},
        '{ONE, ONE, ONE, 0, 0, 0, ONE, 0,      0, 0, 0, 0, 0, 0, 0, 0},
        '{ONE, ONE, ONE, ONE, 0, 0, 0, 0,      0, 0, 0, 0, 0, 0, 0, 0},
        '{ONE, ONE, ONE, 0, ONE, 0, 0, 0,      1, 0, 0, 0, 0, 0, 0, 1},
        '{MINI, MINI, MINI, MINI, MINI, MAXI, MINI, MAXI, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MAXI, MAXI, MAXI, MAXI, MINI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MINI, MAXI, MINI, MINI, MAXI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MAXI, MAXI, MAXI, MAXI, MAXI, MINI, MINI, MINI, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MINI, MINI, MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, 0, 0, 0, 0, 0, 0, 0, 0},
        '{MAXI, MINI, MINI, MINI, MINI, MINI, MAXI, MINI, 0, 0, 0, 0, 0, 0, 0, 0}
    };

    logic i_clk;
    logic i_rst_n;
    ttf_vtx_if vtx ();
    ttf_res_if res ();

    triangle_tangent_frame_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .o_res   (res)
    );

    frame_t  frame_q[$];
    corner_t held[2];
    int      corner_idx;
    int      errors;
    int      n_frames;
    int      n_degen;
    int      n_corners;
    int      wd_count;
    bit      quiet;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= acc + bitv) begin
                v   -= acc + bitv;
                acc  = (acc >> 1) + bitv;
            end else begin
                acc >>= 1;
            end
            bitv >>= 2;
        end
        return acc;
    endfunction

    function automatic logic signed [31:0] round_clip(longint prod);
        longint unsigned mg;
        mg = prod < 0 ? -prod : prod;
        mg = (mg + (64'd1 << 15)) >> 16;
        if (prod < 0) return mg > 64'h80000000 ? MINI : 32'(-longint'(mg));
        return mg > 64'h7fffffff ? MAXI : 32'(mg);
    endfunction

    function automatic frame_t solve_frame(corner_t a, corner_t b, corner_t c);
        frame_t             f;
        logic signed [33:0] e1[3], e2[3];
        logic signed [33:0] d1u, d1v, d2u, d2v;
        logic signed [71:0] det, r[3];
        logic        [71:0] mg[3], any;
        longint unsigned    cs[3], sum, len, q;
        longint             tv[3];
        int                 nb;
        for (int i = 0; i < 3; i++) begin
            e1[i] = b.p[i] - a.p[i];
            e2[i] = c.p[i] - a.p[i];
        end
        d1u = b.uv[0] - a.uv[0];
        d1v = b.uv[1] - a.uv[1];
        d2u = c.uv[0] - a.uv[0];
        d2v = c.uv[1] - a.uv[1];
        det = d1u * d2v - d2u * d1v;
        any = 0;
        for (int i = 0; i < 3; i++) begin
            r[i]  = d2v * e1[i] - d1v * e2[i];
            mg[i] = r[i] < 0 ? -r[i] : r[i];
            any  |= mg[i];
        end
        nb = 0;
        for (int i = 0; i < 72; i++) if (any[i]) nb = i + 1;
        for (int i = 0; i < 3; i++) begin
            f.t[i] = '0;
            f.b[i] = '0;
        end
        f.dg = 1'b1;
        if (det == 0 || nb == 0) return f;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            cs[i] = nb > 31 ? 64'(mg[i] >> (nb - 31)) : 64'(mg[i] << (31 - nb));
            sum  += cs[i] * cs[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q     = ((cs[i] << 16) + (len >> 1)) / len;
            tv[i] = ((r[i] < 0) != (det < 0)) ? -longint'(q) : longint'(q);
            f.t[i] = tv[i][TAN_W-1:0];
        end
        f.b[0] = round_clip(longint'(a.n[1]) * tv[2] - longint'(a.n[2]) * tv[1]);
        f.b[1] = round_clip(longint'(a.n[2]) * tv[0] - longint'(a.n[0]) * tv[2]);
        f.b[2] = round_clip(longint'(a.n[0]) * tv[1] - longint'(a.n[1]) * tv[0]);
        f.dg = 1'b0;
        return f;
    endfunction

    // Returns 1 when this corner closes a triangle, with the predicted frame.
    function automatic bit take_corner(corner_t cn, output frame_t f);
        if (corner_idx == 2) begin
            corner_idx = 0;
            f = solve_frame(held[0], held[1], cn);
            return 1'b1;
        end
        held[corner_idx] = cn;
        corner_idx++;
        return 1'b0;
    endfunction

    task automatic send_corner(corner_t cn, bit typed, frame_t typed_f);
        frame_t f;
        while (!quiet && $urandom_range(0, 99) < 6) begin
            vtx.valid <= 1'b0;
            @(posedge i_clk);
        end
        vtx.valid  <= 1'b1;
        vtx.pos_x  <= cn.p[0];
        vtx.pos_y  <= cn.p[1];
        vtx.pos_z  <= cn.p[2];
        vtx.tex_u  <= cn.uv[0];
        vtx.tex_v  <= cn.uv[1];
        vtx.norm_x <= cn.n[0];
        vtx.norm_y <= cn.n[1];
        vtx.norm_z <= cn.n[2];
        @(posedge i_clk);
        while (!vtx.ready) @(posedge i_clk);
        n_corners++;
        if (take_corner(cn, f)) begin
            if (typed) f = typed_f;
            frame_q.insert(frame_q.size(), f);
            n_frames++;
            if (f.dg) n_degen++;
        end
    endtask

    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
            7:          return MAXI;
            8:          return MINI;
            default:    return 0;
        endcase
    endfunction

    function automatic corner_t rand_corner();
        corner_t cn;
        for (int i = 0; i < 3; i++) cn.p[i] = rand_field();
        for (int i = 0; i < 2; i++) cn.uv[i] = rand_field();
        for (int i = 0; i < 3; i++) cn.n[i] = rand_field();
        return cn;
    endfunction

    always @(posedge i_clk) begin
        if (res.valid && res.ready) begin
            if (frame_q.size() == 0) begin
                $error("result beat with no triangle pending");
                errors++;
            end else begin
                frame_t e;
                e = frame_q.pop_front();
                if (res.tangent_x !== e.t[0]) begin
                    $error("tangent_x exp %0d got %0d", e.t[0], res.tangent_x);
                    errors++;
                end
                if (res.tangent_y !== e.t[1]) begin
                    $error("tangent_y exp %0d got %0d", e.t[1], res.tangent_y);
                    errors++;
                end
                if (res.tangent_z !== e.t[2]) begin
                    $error("tangent_z exp %0d got %0d", e.t[2], res.tangent_z);
                    errors++;
                end
                if (res.bitangent_x !== e.b[0]) begin
                    $error("bitangent_x exp %0d got %0d", e.b[0], res.bitangent_x);
                    errors++;
                end
                if (res.bitangent_y !== e.b[1]) begin
                    $error("bitangent_y exp %0d got %0d", e.b[1], res.bitangent_y);
                    errors++;
                end
                if (res.bitangent_z !== e.b[2]) begin
                    $error("bitangent_z exp %0d got %0d", e.b[2], res.bitangent_z);
                    errors++;
                end
                if (res.degenerate !== e.dg) begin
                    $error("degenerate exp %0b got %0b", e.dg, res.degenerate);
                    errors++;
                end
            end
        end
        if (!i_rst_n) res.ready <= 1'b0;
        else res.ready <= quiet || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
            wd_count <= 0;
        end else begin
            wd_count <= wd_count + 1;
            if (wd_count >= WD_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        corner_t cn;
        frame_t  tf;
        errors     = 0;
        n_frames   = 0;
        n_degen    = 0;
        n_corners  = 0;
        corner_idx = 0;
        quiet      = 1'b0;
        i_rst_n    = 1'b0;
        vtx.valid  = 1'b0;
        vtx.pos_x  = 0;
        vtx.pos_y  = 0;
        vtx.pos_z  = 0;
        vtx.tex_u  = 0;
        vtx.tex_v  = 0;
        vtx.norm_x = 0;
        vtx.norm_y = 0;
        vtx.norm_z = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            cn.p[0]  = dir_tab[k].px;
            cn.p[1]  = dir_tab[k].py;
            cn.p[2]  = dir_tab[k].pz;
            cn.uv[0] = dir_tab[k].u;
            cn.uv[1] = dir_tab[k].v;
            cn.n[0]  = dir_tab[k].nx;
            cn.n[1]  = dir_tab[k].ny;
            cn.n[2]  = dir_tab[k].nz;
            tf.t[0]  = TAN_W'(dir_tab[k].tx);
            tf.t[1]  = TAN_W'(dir_tab[k].ty);
            tf.t[2]  = TAN_W'(dir_tab[k].tz);
            tf.b[0]  = dir_tab[k].bx;
            tf.b[1]  = dir_tab[k].by;
            tf.b[2]  = dir_tab[k].bz;
            tf.dg    = dir_tab[k].dg;
            send_corner(cn, dir_tab[k].chk, tf);
        end

        for (int k = 0; k < N_TRI; k++) begin
            corner_t c0, c1, c2;
            quiet = (k >= 200 && k < 300);
            c0 = rand_corner();
            c1 = rand_corner();
            c2 = rand_corner();
            case ($urandom_range(0, 19))
                0: c2.uv = c1.uv;
                1: c2.p  = c0.p;
                2: begin
                    c1.p = c0.p;
                    c2.p = c0.p;
                end
                default: ;
            endcase
            send_corner(c0, 1'b0, tf);
            send_corner(c1, 1'b0, tf);
            send_corner(c2, 1'b0, tf);
        end
        quiet = 1'b0;
        vtx.valid <= 1'b0;

        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Covered %0d corners, %0d triangle results, %0d degenerate.",
                 n_corners, n_frames, n_degen);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
